[design/ps2mpt_pkg.sv]
package ps2mpt_pkg;

    // Field and register widths fixed by the interface
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 13;
    localparam int unsigned SCR_SIZE_W  = 13;
    localparam int unsigned GAP_W       = 8;
    localparam int unsigned DLIM_W      = 7;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned CURSOR_W    = 12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BYTE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_LIMIT   = 3'd4;

    // Configuration reset values
    localparam logic [SCR_SIZE_W-1:0] RST_SCREEN_WIDTH  = 13'd1024;
    localparam logic [SCR_SIZE_W-1:0] RST_SCREEN_HEIGHT = 13'd768;
    localparam logic [GAP_W-1:0]      RST_GAP_LIMIT     = 8'd25;
    localparam logic [DLIM_W-1:0]     RST_DELTA_LIMIT   = 7'd100;

    // Cursor reset position
    localparam int unsigned RST_POS_X = 512;
    localparam int unsigned RST_POS_Y = 384;

    // Input mode codes
    localparam logic MODE_BYTE    = 1'b0;
    localparam logic MODE_SET_POS = 1'b1;

    // Bits of the packet start byte
    localparam int unsigned BIT_LEFT   = 0;
    localparam int unsigned BIT_RIGHT  = 1;
    localparam int unsigned BIT_MIDDLE = 2;
    localparam int unsigned BIT_SYNC   = 3;
    localparam int unsigned BIT_X_OVF  = 6;
    localparam int unsigned BIT_Y_OVF  = 7;

    // Position within a packet
    typedef enum logic [3:0] {
        PH_START = 4'b0001,
        PH_X     = 4'b0010,
        PH_Y     = 4'b0100,
        PH_WHEEL = 4'b1000
    } phase_t;

endpackage

[design/ps2_mouse_packet_tracker_core.sv]
// Channel   Direction  Handshake          Word
// s_        in         s_valid / s_ready  mode, data_byte, now_ms, absolute_active, new_x, new_y
// m_        out        m_valid / m_ready  move_x, move_y, cursor_x/y, button bits
// cfg_      in         cfg_wr_en          cfg_index, cfg_wdata (no wait, no read-back)
//
// One word is taken per cycle unless a waiting result stalls: a word goes into the
// input register, and as it leaves, the framing, clamping and cursor logic updates the
// state and, when the word completes a packet, loads the result register.
// A waiting result stalls the input register only while m_ready is low.
// aresetn is synchronous and active low; it restores the default configuration,
// clears the framing state and puts the cursor at 512, 384.
module ps2_mouse_packet_tracker_core
    import ps2mpt_pkg::*;
#(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_mode,
    input  logic [7:0]              s_data_byte,
    input  logic [TIME_W-1:0]       s_now_ms,
    input  logic                    s_absolute_active,
    input  logic signed [31:0]      s_new_x,
    input  logic signed [31:0]      s_new_y,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [7:0]       m_move_x,
    output logic signed [7:0]       m_move_y,
    output logic [CURSOR_W-1:0]     m_cursor_x,
    output logic [CURSOR_W-1:0]     m_cursor_y,
    output logic                    m_left_pressed,
    output logic                    m_right_pressed,
    output logic                    m_middle_pressed
);

    // Width for comparing a screen limit with the coordinate ceiling
    localparam int unsigned LW = (COORD_BITS > SCR_SIZE_W) ? COORD_BITS + 1 : SCR_SIZE_W + 1;
    // Width of a signed cursor sum
    localparam int unsigned SW = COORD_BITS + 2;
    localparam logic [LW-1:0] COORD_TOP = LW'((64'd1 << COORD_BITS) - 64'd1);

    // Configuration registers
    logic [SCR_SIZE_W-1:0] screen_width_reg;
    logic [SCR_SIZE_W-1:0] screen_height_reg;
    logic                four_byte_reg;
    logic [GAP_W-1:0]    gap_limit_reg;
    logic [DLIM_W-1:0]   delta_limit_reg;

    // Input register
    logic                in_valid_reg;
    logic                in_mode_reg;
    logic [7:0]          in_data_reg;
    logic [TIME_W-1:0]   in_now_reg;
    logic                in_abs_reg;
    logic signed [31:0]  in_new_x_reg;
    logic signed [31:0]  in_new_y_reg;

    // Tracker state
    phase_t              phase_reg, phase_next;
    logic [7:0]          first_byte_reg, first_byte_next;
    logic [7:0]          x_byte_reg, x_byte_next;
    logic [7:0]          y_byte_reg, y_byte_next;
    logic [TIME_W-1:0]   last_time_reg, last_time_next;
    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0] pos_y_reg, pos_y_next;

    // Result register
    logic                out_valid_reg;
    logic signed [7:0]   out_move_x_reg, out_move_x_next;
    logic signed [7:0]   out_move_y_reg, out_move_y_next;
    logic [COORD_BITS-1:0] out_pos_x_reg;
    logic [COORD_BITS-1:0] out_pos_y_reg;
    logic [2:0]          out_buttons_reg;

    logic                advance;
    logic                done;
    logic [COORD_BITS-1:0] limit_x;
    logic [COORD_BITS-1:0] limit_y;

    // Configuration writes; a zero screen size is ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= RST_SCREEN_WIDTH;
            screen_height_reg <= RST_SCREEN_HEIGHT;
            four_byte_reg     <= 1'b0;
            gap_limit_reg     <= RST_GAP_LIMIT;
            delta_limit_reg   <= RST_DELTA_LIMIT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SCREEN_WIDTH: begin
                    if (cfg_wdata != '0) screen_width_reg <= cfg_wdata;
                end
                CFG_SCREEN_HEIGHT: begin
                    if (cfg_wdata != '0) screen_height_reg <= cfg_wdata;
                end
                CFG_FOUR_BYTE:   four_byte_reg   <= cfg_wdata[0];
                CFG_GAP_LIMIT:   gap_limit_reg   <= cfg_wdata[GAP_W-1:0];
                CFG_DELTA_LIMIT: delta_limit_reg <= cfg_wdata[DLIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Cursor limits: screen size minus one, capped at the coordinate ceiling
    always_comb begin
        logic [LW-1:0] lx;
        logic [LW-1:0] ly;
        lx = LW'(screen_width_reg - 1'b1);
        ly = LW'(screen_height_reg - 1'b1);
        limit_x = COORD_BITS'((lx < COORD_TOP) ? lx : COORD_TOP);
        limit_y = COORD_BITS'((ly < COORD_TOP) ? ly : COORD_TOP);
    end

    // Handshake: the input register moves on whenever the result register can take a word
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg  <= s_mode;
            in_data_reg  <= s_data_byte;
            in_now_reg   <= s_now_ms;
            in_abs_reg   <= s_absolute_active;
            in_new_x_reg <= s_new_x;
            in_new_y_reg <= s_new_y;
        end
    end

    // Framing, delta clamping and cursor update for the word in the input register
    always_comb begin
        phase_t              eff_phase;
        logic [TIME_W-1:0]   gap;
        logic [7:0]          y_cur;
        logic signed [8:0]   dx;
        logic signed [9:0]   dy;
        logic signed [9:0]   lim_s;
        logic signed [SW-1:0] sum_x;
        logic signed [SW-1:0] sum_y;

        phase_next      = phase_reg;
        first_byte_next = first_byte_reg;
        x_byte_next     = x_byte_reg;
        y_byte_next     = y_byte_reg;
        last_time_next  = last_time_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        done            = 1'b0;
        y_cur           = y_byte_reg;

        // Resynchronise when the mid-packet gap is too long
        gap       = in_now_reg - last_time_reg;
        eff_phase = phase_reg;
        if (phase_reg != PH_START && gap > TIME_W'(gap_limit_reg)) begin
            eff_phase = PH_START;
        end

        if (in_mode_reg == MODE_SET_POS) begin
            // Load the cursor, clamped to the screen
            if (in_new_x_reg < 0) begin
                pos_x_next = '0;
            end else if (in_new_x_reg > signed'(32'(limit_x))) begin
                pos_x_next = limit_x;
            end else begin
                pos_x_next = COORD_BITS'(in_new_x_reg);
            end
            if (in_new_y_reg < 0) begin
                pos_y_next = '0;
            end else if (in_new_y_reg > signed'(32'(limit_y))) begin
                pos_y_next = limit_y;
            end else begin
                pos_y_next = COORD_BITS'(in_new_y_reg);
            end
        end else begin
            last_time_next = in_now_reg;
            phase_next     = eff_phase;
            case (eff_phase)
                PH_START: begin
                    if (in_data_reg[BIT_SYNC] && !in_data_reg[BIT_X_OVF]
                        && !in_data_reg[BIT_Y_OVF]) begin
                        first_byte_next = in_data_reg;
                        phase_next      = PH_X;
                    end
                end
                PH_X: begin
                    x_byte_next = in_data_reg;
                    phase_next  = PH_Y;
                end
                PH_Y: begin
                    y_byte_next = in_data_reg;
                    y_cur       = in_data_reg;
                    if (four_byte_reg) begin
                        phase_next = PH_WHEEL;
                    end else begin
                        phase_next = PH_START;
                        done       = 1'b1;
                    end
                end
                PH_WHEEL: begin
                    phase_next = PH_START;
                    done       = 1'b1;
                end
                default: begin
                    phase_next = PH_START;
                end
            endcase
        end

        // Sign-extend, drop an overflowed axis, flip Y and clamp both deltas
        dx = first_byte_reg[BIT_X_OVF] ? 9'sd0 : 9'(signed'(x_byte_reg));
        dy = first_byte_reg[BIT_Y_OVF] ? 10'sd0 : -10'(signed'(y_cur));
        lim_s = signed'(10'(delta_limit_reg));
        if (10'(dx) > lim_s) begin
            dx = 9'(lim_s);
        end else if (10'(dx) < -lim_s) begin
            dx = 9'(-lim_s);
        end
        if (dy > lim_s) begin
            dy = lim_s;
        end else if (dy < -lim_s) begin
            dy = -lim_s;
        end
        out_move_x_next = 8'(dx);
        out_move_y_next = 8'(dy);

        // Move the cursor unless absolute pointing owns it
        sum_x = signed'(SW'(pos_x_reg)) + SW'(out_move_x_next);
        sum_y = signed'(SW'(pos_y_reg)) + SW'(out_move_y_next);
        if (done && !in_abs_reg) begin
            if (sum_x < 0) begin
                pos_x_next = '0;
            end else if (sum_x > signed'(SW'(limit_x))) begin
                pos_x_next = limit_x;
            end else begin
                pos_x_next = COORD_BITS'(sum_x);
            end
            if (sum_y < 0) begin
                pos_y_next = '0;
            end else if (sum_y > signed'(SW'(limit_y))) begin
                pos_y_next = limit_y;
            end else begin
                pos_y_next = COORD_BITS'(sum_y);
            end
        end
    end

    // Tracker state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_START;
            first_byte_reg <= '0;
            x_byte_reg     <= '0;
            y_byte_reg     <= '0;
            last_time_reg  <= '0;
            pos_x_reg      <= COORD_BITS'(RST_POS_X);
            pos_y_reg      <= COORD_BITS'(RST_POS_Y);
        end else if (advance) begin
            phase_reg      <= phase_next;
            first_byte_reg <= first_byte_next;
            x_byte_reg     <= x_byte_next;
            y_byte_reg     <= y_byte_next;
            last_time_reg  <= last_time_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && done) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && done) begin
            out_move_x_reg  <= out_move_x_next;
            out_move_y_reg  <= out_move_y_next;
            out_pos_x_reg   <= pos_x_next;
            out_pos_y_reg   <= pos_y_next;
            out_buttons_reg <= {first_byte_reg[BIT_MIDDLE], first_byte_reg[BIT_RIGHT],
                                first_byte_reg[BIT_LEFT]};
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_move_x         = out_move_x_reg;
    assign m_move_y         = out_move_y_reg;
    assign m_cursor_x       = CURSOR_W'(out_pos_x_reg);
    assign m_cursor_y       = CURSOR_W'(out_pos_y_reg);
    assign m_left_pressed   = out_buttons_reg[0];
    assign m_right_pressed  = out_buttons_reg[1];
    assign m_middle_pressed = out_buttons_reg[2];

`ifndef SYNTH
    // A finished packet always shows up as a result word in the next cycle
    a_done_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && done |=> m_valid)
        else $error("completed packet did not produce a result word");

    // A set-position word never disturbs packet framing
    a_setpos_keeps_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_mode_reg == MODE_SET_POS |=> $stable(phase_reg))
        else $error("set-position word changed the packet phase");

    // Reported deltas respect the clamp bound
    a_delta_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_move_x <= signed'(8'(delta_limit_reg))
                     && m_move_x >= -signed'(8'(delta_limit_reg))
                     && m_move_y <= signed'(8'(delta_limit_reg))
                     && m_move_y >= -signed'(8'(delta_limit_reg))))
        else $error("result delta exceeds the clamp bound");
`endif

endmodule
